>>> hw/rtl/binary_morphology_dilate_erode_top_defines.svh
// ----------------------------------------------------------------------------
// binary_morphology_dilate_erode_top_defines.svh
// Assertion macros shared by the morphology block; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef BINARY_MORPHOLOGY_DILATE_ERODE_TOP_DEFINES_SVH
`define BINARY_MORPHOLOGY_DILATE_ERODE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define BMDE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define BMDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BMDE_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define BMDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/bmde_pkg.sv
// ----------------------------------------------------------------------------
// bmde_pkg
// Shared sizes, register codes and types of the binary morphology block.
// ----------------------------------------------------------------------------
package bmde_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 4096;
    localparam int WINDOW   = 5;
    localparam int HALF     = WINDOW / 2;

    localparam int ROW_W    = 12;
    localparam int ROWS_W   = 13;
    localparam int COLS_W   = 7;
    localparam int MASK_W   = WINDOW * WINDOW;
    localparam int PAD_W    = MAX_COLS + 2 * HALF;
    localparam int SKIP_W   = $clog2(HALF + 1);
    localparam int CNT_W    = $clog2(HALF + 2);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 25;

    localparam logic [ROWS_W-1:0] MAX_ROWS_V = ROWS_W'(MAX_ROWS);
    localparam logic [COLS_W-1:0] MAX_COLS_V = COLS_W'(MAX_COLS);
    localparam logic [ROW_W-1:0]  HALF_ROW   = ROW_W'(HALF);

    // mode codes
    localparam logic MODE_DILATE = 1'b0;
    localparam logic MODE_ERODE  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE  = 2'd0,
        CFG_ROWS  = 2'd1,
        CFG_COLS  = 2'd2,
        CFG_MASK  = 2'd3
    } cfg_index_t;

    typedef logic [MAX_COLS-1:0] row_t;

    // status of the result sequencer as seen by the output side
    typedef struct packed {
        logic             valid;
        logic             emit;
        logic [ROW_W-1:0] row;
        logic             last;
    } job_t;

endpackage

>>> hw/rtl/bmde_lane.sv
// ----------------------------------------------------------------------------
// bmde_lane
// One output column: applies the structuring element to its 5x5 neighborhood.
// ----------------------------------------------------------------------------
module bmde_lane
    import bmde_pkg::*;
(
    input  logic [MASK_W-1:0] nb,
    input  logic [MASK_W-1:0] se_mask,
    input  logic              mode,
    input  logic              col_en,
    output logic              pix
);

    logic hit_any;
    logic hit_all;

    // or over selected cells for dilation, and over selected cells for erosion
    assign hit_any = |(nb & se_mask);
    assign hit_all = &(nb | ~se_mask);
    assign pix     = col_en & ((mode == MODE_ERODE) ? hit_all : hit_any);

endmodule

>>> hw/rtl/bmde_front.sv
// ----------------------------------------------------------------------------
// bmde_front
// Line store, row counter and the sequencer that issues up to three result
// windows per accepted row.
// ----------------------------------------------------------------------------
`include "binary_morphology_dilate_erode_top_defines.svh"

module bmde_front
    import bmde_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  row_t              row_bits,
    input  row_t              col_mask,
    input  logic [ROWS_W-1:0] eff_rows,
    input  logic              out_free,
    output job_t              job,
    output row_t              win [WINDOW]
);

    row_t             store_reg [WINDOW-1];
    row_t             store_next [WINDOW-1];
    logic [ROW_W-1:0] n_reg;
    logic [ROW_W-1:0] n_next;

    row_t             job_win_reg [WINDOW];
    row_t             job_win_next [WINDOW];
    logic [ROW_W-1:0] job_row_reg;
    logic [ROW_W-1:0] job_row_next;
    logic [CNT_W-1:0] job_cnt_reg;
    logic [CNT_W-1:0] job_cnt_next;
    logic             job_last_reg;
    logic             job_last_next;
    logic             job_valid_reg;
    logic             job_valid_next;

    logic             accept;
    logic             emit;
    logic             last_in;
    logic             has_half;
    logic [SKIP_W-1:0] skip;
    logic [CNT_W-1:0] cnt_new;
    row_t             w_in [WINDOW];
    row_t             w_new [WINDOW];

    // handshake
    assign emit     = job_valid_reg & out_free;
    assign in_ready = ~job_valid_reg | (emit & (job_cnt_reg == CNT_W'(1)));
    assign accept   = in_valid & in_ready;

    // frame end and how many rows of the window are already past the top
    assign last_in  = ({1'b0, n_reg} + ROWS_W'(1)) >= eff_rows;
    assign has_half = n_reg >= HALF_ROW;

    always_comb
    begin
        skip    = '0;
        cnt_new = '0;
        if (last_in)
        begin
            if (!has_half)
            begin
                skip = SKIP_W'(HALF_ROW - n_reg);
            end
            cnt_new = CNT_W'(HALF + 1) - CNT_W'(skip);
        end
        else if (has_half)
        begin
            cnt_new = CNT_W'(1);
        end
    end

    // window of the arriving row, shifted up past rows above the frame
    always_comb
    begin
        for (int i = 0; i < WINDOW - 1; i++)
        begin
            w_in[i] = store_reg[i] & col_mask;
        end
        w_in[WINDOW-1] = row_bits & col_mask;
        for (int i = 0; i < WINDOW; i++)
        begin
            w_new[i] = '0;
            for (int s = 0; s <= HALF; s++)
            begin
                if (skip == SKIP_W'(s) && i + s < WINDOW)
                begin
                    w_new[i] = w_in[i + s];
                end
            end
        end
    end

    // line store and row counter
    always_comb
    begin
        for (int i = 0; i < WINDOW - 1; i++)
        begin
            store_next[i] = store_reg[i];
        end
        n_next = n_reg;
        if (accept)
        begin
            if (last_in)
            begin
                for (int i = 0; i < WINDOW - 1; i++)
                begin
                    store_next[i] = '0;
                end
                n_next = '0;
            end
            else
            begin
                for (int i = 0; i < WINDOW - 2; i++)
                begin
                    store_next[i] = store_reg[i + 1];
                end
                store_next[WINDOW-2] = row_bits & col_mask;
                n_next = n_reg + ROW_W'(1);
            end
        end
    end

    // result sequencer
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            job_win_next[i] = job_win_reg[i];
        end
        job_row_next   = job_row_reg;
        job_cnt_next   = job_cnt_reg;
        job_last_next  = job_last_reg;
        job_valid_next = job_valid_reg;
        if (emit)
        begin
            for (int i = 0; i < WINDOW - 1; i++)
            begin
                job_win_next[i] = job_win_reg[i + 1];
            end
            job_win_next[WINDOW-1] = '0;
            job_row_next = job_row_reg + ROW_W'(1);
            job_cnt_next = job_cnt_reg - CNT_W'(1);
            if (job_cnt_reg == CNT_W'(1))
            begin
                job_valid_next = 1'b0;
            end
        end
        if (accept && cnt_new != '0)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                job_win_next[i] = w_new[i];
            end
            job_row_next   = n_reg - HALF_ROW + ROW_W'(skip);
            job_cnt_next   = cnt_new;
            job_last_next  = last_in;
            job_valid_next = 1'b1;
        end
    end

    // control and line store registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW - 1; i++)
            begin
                store_reg[i] <= '0;
            end
            n_reg         <= '0;
            job_cnt_reg   <= '0;
            job_last_reg  <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < WINDOW - 1; i++)
            begin
                store_reg[i] <= store_next[i];
            end
            n_reg         <= n_next;
            job_cnt_reg   <= job_cnt_next;
            job_last_reg  <= job_last_next;
            job_valid_reg <= job_valid_next;
        end
    end

    // window and row index payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            job_win_reg[i] <= job_win_next[i];
        end
        job_row_reg <= job_row_next;
    end

    always_comb
    begin
        job.valid = job_valid_reg;
        job.emit  = emit;
        job.row   = job_row_reg;
        job.last  = job_last_reg & (job_cnt_reg == CNT_W'(1));
        for (int i = 0; i < WINDOW; i++)
        begin
            win[i] = job_win_reg[i];
        end
    end

    // checks
    `BMDE_ASSERT_NOW(a_cnt_live, clk, rst_n, job_valid_reg, job_cnt_reg != '0)
    `BMDE_ASSERT_NEXT(a_frame_clear, clk, rst_n, accept && last_in, n_reg == '0)
    `BMDE_ASSERT_NEXT(a_flush_full, clk, rst_n, accept && last_in && has_half,
        job_valid_reg && job_cnt_reg == CNT_W'(HALF + 1) && job_last_reg)
    `BMDE_ASSERT_NOW(a_no_overrun, clk, rst_n, accept && job_valid_reg,
        emit && job_cnt_reg == CNT_W'(1))

endmodule

>>> hw/rtl/binary_morphology_dilate_erode_top.sv
// ----------------------------------------------------------------------------
// binary_morphology_dilate_erode_top
// A completing row is registered in the sequencer, and its result row then
// in the output register. Throughput: one row per cycle while the output is
// ready; with the output ready, the final row of a frame holds input while
// its up to three result rows drain, one per cycle.
// Reset: clears store, row count, sequencer, output valid; config to defaults.
// ----------------------------------------------------------------------------
`include "binary_morphology_dilate_erode_top_defines.svh"

module binary_morphology_dilate_erode_top
    import bmde_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MAX_COLS-1:0]   row_bits,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ROW_W-1:0]      row_index,
    output logic [MAX_COLS-1:0]   out_bits,
    output logic                  last_row,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic              mode_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic [COLS_W-1:0] cols_reg;
    logic [MASK_W-1:0] mask_reg;

    logic [ROWS_W-1:0] eff_rows;
    logic [COLS_W-1:0] eff_cols;
    row_t              col_mask;

    job_t              job;
    row_t              win [WINDOW];
    logic [PAD_W-1:0]  pad [WINDOW];
    row_t              lane_bits;

    logic              out_valid_reg;
    logic [ROW_W-1:0]  row_index_reg;
    row_t              out_bits_reg;
    logic              last_row_reg;
    logic              out_free;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_DILATE;
            rows_reg <= ROWS_W'(1);
            cols_reg <= MAX_COLS_V;
            mask_reg <= '1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MODE: mode_reg <= cfg_data[0];
                CFG_ROWS: mode_reg <= mode_reg;
                default:  mode_reg <= mode_reg;
            endcase
            case (cfg_index_t'(cfg_index))
                CFG_ROWS: rows_reg <= cfg_data[ROWS_W-1:0];
                CFG_COLS: cols_reg <= cfg_data[COLS_W-1:0];
                CFG_MASK: mask_reg <= cfg_data[MASK_W-1:0];
                default:  rows_reg <= rows_reg;
            endcase
        end
    end

    // clamped frame size and column mask
    always_comb
    begin
        eff_rows = rows_reg;
        if (rows_reg == '0)
        begin
            eff_rows = ROWS_W'(1);
        end
        else if (rows_reg > MAX_ROWS_V)
        begin
            eff_rows = MAX_ROWS_V;
        end
        eff_cols = cols_reg;
        if (cols_reg == '0)
        begin
            eff_cols = COLS_W'(1);
        end
        else if (cols_reg > MAX_COLS_V)
        begin
            eff_cols = MAX_COLS_V;
        end
        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_mask[c] = COLS_W'(c) < eff_cols;
        end
    end

    // line store and result sequencer
    bmde_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .row_bits (row_bits),
        .col_mask (col_mask),
        .eff_rows (eff_rows),
        .out_free (out_free),
        .job      (job),
        .win      (win)
    );

    // window rows padded with background on both sides
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            pad[i] = {{HALF{1'b0}}, win[i], {HALF{1'b0}}};
        end
    end

    // one lane per column
    for (genvar c = 0; c < MAX_COLS; c++)
    begin : g_lane
        logic [MASK_W-1:0] nb;
        for (genvar i = 0; i < WINDOW; i++)
        begin : g_row
            assign nb[i*WINDOW +: WINDOW] = pad[i][c +: WINDOW];
        end
        bmde_lane u_lane (
            .nb      (nb),
            .se_mask (mask_reg),
            .mode    (mode_reg),
            .col_en  (col_mask[c]),
            .pix     (lane_bits[c])
        );
    end

    // output register collecting the lane results
    assign out_free = ~out_valid_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (job.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job.emit)
        begin
            row_index_reg <= job.row;
            out_bits_reg  <= lane_bits;
            last_row_reg  <= job.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_index = row_index_reg;
    assign out_bits  = out_bits_reg;
    assign last_row  = last_row_reg;

    // checks
    `BMDE_ASSERT_NOW(a_emit_room, clk, rst_n, job.emit, job.valid && out_free)
    `BMDE_ASSERT_NEXT(a_emit_shows, clk, rst_n, job.emit, out_valid_reg)
    `BMDE_ASSERT_NEXT(a_last_drain, clk, rst_n, job.emit && job.last, !job.valid || job.row == '0)

endmodule
